/* rtl/lps_pkg.sv */
// Package for the LED pattern sequencer: sizes, operation codes and the pattern ROM.
// Used by led_pattern_sequencer, lps_pattern_checker and the testbench; it depends on nothing else.
`default_nettype none

package lps_pkg;

	localparam int NUM_PATTERNS = 15;
	localparam int MAX_STEPS    = 6;
	localparam int PIN_COUNT    = 16;

	localparam int PAT_W   = $clog2(NUM_PATTERNS);
	localparam int STEP_W  = 3;
	localparam int CNT_W   = 3;
	localparam int MS_W    = 15;
	localparam int ROM_MS_W = 12;

	localparam logic [PIN_COUNT-1:0] USED_PIN_MASK_RESET = 16'hC000;

	typedef enum logic {
		OP_PLAY = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic [PIN_COUNT-1:0] mask;
		logic                 lit;
		logic [ROM_MS_W-1:0]  ms;
	} step_t;

	localparam step_t NONE = '{mask: 16'h0000, lit: 1'b0, ms: 12'd0};

	localparam step_t BOTH_OFF_0    = '{mask: 16'hC000, lit: 1'b0, ms: 12'd0};
	localparam step_t LO_ON_1000    = '{mask: 16'h4000, lit: 1'b1, ms: 12'd1000};
	localparam step_t LO_OFF_200    = '{mask: 16'h4000, lit: 1'b0, ms: 12'd200};
	localparam step_t HI_ON_1000    = '{mask: 16'h8000, lit: 1'b1, ms: 12'd1000};
	localparam step_t HI_OFF_200    = '{mask: 16'h8000, lit: 1'b0, ms: 12'd200};
	localparam step_t LO_ON_100     = '{mask: 16'h4000, lit: 1'b1, ms: 12'd100};
	localparam step_t LO_OFF_100    = '{mask: 16'h4000, lit: 1'b0, ms: 12'd100};
	localparam step_t LO_OFF_2400   = '{mask: 16'h4000, lit: 1'b0, ms: 12'd2400};
	localparam step_t HI_ON_100     = '{mask: 16'h8000, lit: 1'b1, ms: 12'd100};
	localparam step_t HI_OFF_100    = '{mask: 16'h8000, lit: 1'b0, ms: 12'd100};
	localparam step_t HI_OFF_2400   = '{mask: 16'h8000, lit: 1'b0, ms: 12'd2400};
	localparam step_t HI_OFF_1000   = '{mask: 16'h8000, lit: 1'b0, ms: 12'd1000};
	localparam step_t LO_OFF_1000   = '{mask: 16'h4000, lit: 1'b0, ms: 12'd1000};
	localparam step_t BOTH_ON_100   = '{mask: 16'hC000, lit: 1'b1, ms: 12'd100};
	localparam step_t BOTH_OFF_100  = '{mask: 16'hC000, lit: 1'b0, ms: 12'd100};
	localparam step_t BOTH_ON_1000  = '{mask: 16'hC000, lit: 1'b1, ms: 12'd1000};
	localparam step_t BOTH_OFF_1000 = '{mask: 16'hC000, lit: 1'b0, ms: 12'd1000};

	localparam step_t PAT_ROM [NUM_PATTERNS][MAX_STEPS] = '{
		'{BOTH_OFF_0, NONE, NONE, NONE, NONE, NONE},
		'{LO_ON_1000, LO_OFF_200, NONE, NONE, NONE, NONE},
		'{HI_ON_1000, HI_OFF_200, NONE, NONE, NONE, NONE},
		'{LO_ON_100, LO_OFF_2400, NONE, NONE, NONE, NONE},
		'{HI_ON_100, HI_OFF_2400, NONE, NONE, NONE, NONE},
		'{LO_ON_100, LO_OFF_100, LO_ON_100, LO_OFF_2400, NONE, NONE},
		'{HI_ON_100, HI_OFF_100, HI_ON_100, HI_OFF_2400, NONE, NONE},
		'{LO_ON_100, LO_OFF_100, LO_ON_100, LO_OFF_100, LO_ON_100, LO_OFF_2400},
		'{HI_ON_100, HI_OFF_100, HI_ON_100, HI_OFF_100, HI_ON_100, HI_OFF_2400},
		'{HI_ON_100, HI_OFF_100, LO_ON_100, LO_OFF_100, NONE, NONE},
		'{HI_ON_1000, HI_OFF_1000, LO_ON_1000, LO_OFF_1000, NONE, NONE},
		'{BOTH_ON_100, BOTH_OFF_100, NONE, NONE, NONE, NONE},
		'{BOTH_ON_1000, BOTH_OFF_1000, NONE, NONE, NONE, NONE},
		'{BOTH_ON_1000, BOTH_OFF_100, NONE, NONE, NONE, NONE},
		'{HI_ON_100, HI_OFF_100, HI_ON_100, HI_OFF_100, HI_ON_100, HI_OFF_100}
	};

	localparam logic [CNT_W-1:0] PAT_COUNT [NUM_PATTERNS] = '{
		3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd6,
		3'd6, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd6
	};

	// Bit n is set when pattern n loops forever; the others play once.
	localparam logic [NUM_PATTERNS-1:0] PAT_REPEATS = 15'b001_1111_1111_1111;

	function automatic logic [PAT_W-1:0] row_of(input logic [PAT_W-1:0] p);
		row_of = (p < PAT_W'(NUM_PATTERNS)) ? p : '0;
	endfunction

	function automatic logic [CNT_W-1:0] count_of(input logic [PAT_W-1:0] p);
		count_of = PAT_COUNT[row_of(p)];
	endfunction

	function automatic logic repeats(input logic [PAT_W-1:0] p);
		repeats = PAT_REPEATS[row_of(p)];
	endfunction

	function automatic step_t step_of(input logic [PAT_W-1:0] p, input logic [STEP_W-1:0] s);
		step_of = (s < STEP_W'(MAX_STEPS)) ? PAT_ROM[row_of(p)][s] : NONE;
	endfunction

endpackage

`default_nettype wire

/* rtl/led_pattern_sequencer.sv */
// Top level of the LED pattern sequencer: input register, step logic and state, result register.
// Depends on lps_pkg for the pattern ROM, the operation codes and the sizes.
//
// Channel  Direction  Handshake            Payload
// in       to block   in_valid / in_stall  op, pattern
// out      from block out_valid / out_stall pin_levels, pin_drive_enable, accepted, playing_pattern
// cfg      to block   cfg_valid / cfg_ready cfg_data (used pin mask)
//
// Each beat waits in the input register until its result is loaded into the result register.
// One input beat is taken in every cycle while the output side is not stalled.
// The state update and the result register load in the same edge, so the result beat
// shows the state the item left behind; a stalled result freezes the state and the input register.
// Reset clears all state and sets the used pin mask to 0xC000; cfg_ready is always high.
`default_nettype none

module led_pattern_sequencer (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          op,
	input  wire  [3:0]                   pattern,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [15:0]                  pin_levels,
	output logic [15:0]                  pin_drive_enable,
	output logic                         accepted,
	output logic [3:0]                   playing_pattern,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [15:0]                  cfg_data
);

	logic                              valid_s1;
	logic                              op_s1;
	logic [lps_pkg::PAT_W-1:0]         pattern_s1;
	logic                              out_valid_q;
	logic                              proc_en;
	logic                              do_item;

	logic [lps_pkg::PIN_COUNT-1:0]     used_mask_q;
	logic [lps_pkg::PAT_W-1:0]         now_pattern_q, resume_pattern_q;
	logic [lps_pkg::STEP_W-1:0]        now_step_q, resume_step_q;
	logic [lps_pkg::MS_W-1:0]          ms_left_q;
	logic                              timer_q;
	logic [lps_pkg::PIN_COUNT-1:0]     level_q, drive_q;
	logic                              acc_q;

	logic [lps_pkg::PAT_W-1:0]         now_pattern_d, resume_pattern_d;
	logic [lps_pkg::STEP_W-1:0]        now_step_d, resume_step_d;
	logic [lps_pkg::MS_W-1:0]          ms_left_d;
	logic                              timer_d;
	logic [lps_pkg::PIN_COUNT-1:0]     level_d, drive_d;
	logic                              acc_d;

	logic                              do_adv;
	logic [lps_pkg::PAT_W-1:0]         pre_pat, adv_pat;
	logic [lps_pkg::STEP_W-1:0]        pre_step, adv_step;
	logic [lps_pkg::PIN_COUNT-1:0]     pre_level, pre_drive;
	logic [lps_pkg::CNT_W-1:0]         adv_cnt;
	lps_pkg::step_t                    adv_st;

	assign proc_en   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !proc_en;
	assign do_item   = valid_s1 && proc_en;
	assign cfg_ready = 1'b1;

	assign out_valid        = out_valid_q;
	assign pin_levels       = level_q;
	assign pin_drive_enable = drive_q;
	assign accepted         = acc_q;
	assign playing_pattern  = now_pattern_q;

	always_comb begin
		now_pattern_d    = now_pattern_q;
		now_step_d       = now_step_q;
		resume_pattern_d = resume_pattern_q;
		resume_step_d    = resume_step_q;
		ms_left_d        = ms_left_q;
		timer_d          = timer_q;
		acc_d            = 1'b0;
		do_adv           = 1'b0;
		pre_pat          = now_pattern_q;
		pre_step         = now_step_q;
		pre_level        = level_q;
		pre_drive        = drive_q;

		if (lps_pkg::op_t'(op_s1) == lps_pkg::OP_PLAY) begin
			if (pattern_s1 < lps_pkg::PAT_W'(lps_pkg::NUM_PATTERNS)) begin
				if (lps_pkg::repeats(now_pattern_q)) begin
					if (lps_pkg::repeats(pattern_s1)) begin
						resume_pattern_d = pattern_s1;
						resume_step_d    = '0;
					end else begin
						resume_pattern_d = now_pattern_q;
						resume_step_d    = now_step_q;
					end
					pre_pat  = pattern_s1;
					pre_step = '0;
					acc_d    = 1'b1;
				end else if (lps_pkg::repeats(pattern_s1)) begin
					resume_pattern_d = pattern_s1;
					resume_step_d    = '0;
					acc_d            = 1'b1;
				end
			end
			if (acc_d) begin
				pre_level = level_q & ~used_mask_q;
				pre_drive = drive_q | used_mask_q;
				do_adv    = 1'b1;
			end
		end else if (timer_q) begin
			if (ms_left_q > lps_pkg::MS_W'(1)) begin
				ms_left_d = ms_left_q - lps_pkg::MS_W'(1);
			end else begin
				do_adv = 1'b1;
			end
		end

		adv_pat  = pre_pat;
		adv_step = pre_step;
		if (pre_step >= lps_pkg::count_of(pre_pat)) begin
			if (lps_pkg::repeats(pre_pat)) begin
				adv_step = '0;
			end else begin
				adv_pat  = resume_pattern_d;
				adv_step = resume_step_d;
				if (lps_pkg::repeats(resume_pattern_d)) begin
					adv_step = '0;
				end
			end
		end
		adv_cnt = lps_pkg::count_of(adv_pat);
		if (adv_step >= adv_cnt) begin
			adv_step = '0;
		end
		adv_st = lps_pkg::step_of(adv_pat, adv_step);

		level_d = pre_level;
		drive_d = pre_drive;
		if (do_adv) begin
			level_d       = (pre_level & ~adv_st.mask) | (adv_st.lit ? adv_st.mask : '0);
			drive_d       = pre_drive | adv_st.mask;
			now_pattern_d = adv_pat;
			now_step_d    = adv_step + lps_pkg::STEP_W'(1);
			timer_d       = (adv_cnt != lps_pkg::CNT_W'(1));
			if (adv_cnt != lps_pkg::CNT_W'(1)) begin
				ms_left_d = lps_pkg::MS_W'(adv_st.ms);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (proc_en) begin
				valid_s1 <= 1'b0;
			end
			if (proc_en) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= op;
			pattern_s1 <= pattern;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_mask_q <= lps_pkg::USED_PIN_MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			used_mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_pattern_q    <= '0;
			now_step_q       <= '0;
			resume_pattern_q <= '0;
			resume_step_q    <= '0;
			ms_left_q        <= '0;
			timer_q          <= 1'b0;
			level_q          <= '0;
			drive_q          <= '0;
			acc_q            <= 1'b0;
		end else if (do_item) begin
			now_pattern_q    <= now_pattern_d;
			now_step_q       <= now_step_d;
			resume_pattern_q <= resume_pattern_d;
			resume_step_q    <= resume_step_d;
			ms_left_q        <= ms_left_d;
			timer_q          <= timer_d;
			level_q          <= level_d;
			drive_q          <= drive_d;
			acc_q            <= acc_d;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_bad_pattern_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(do_item && op_s1 == lps_pkg::OP_PLAY
			&& pattern_s1 >= lps_pkg::PAT_W'(lps_pkg::NUM_PATTERNS))
		|=> (!acc_q && $stable(now_pattern_q)))
		else $error("out of range pattern was accepted");

	a_drive_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((drive_q & $past(drive_q)) == $past(drive_q)))
		else $error("a driven pin lost its drive enable");

	a_pattern_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (now_pattern_q < lps_pkg::PAT_W'(lps_pkg::NUM_PATTERNS)))
		else $error("playing pattern out of range");

endmodule

`default_nettype wire

/* dv/lps_pattern_checker.sv */
// Checker for the LED pattern sequencer: watches the input, output and mask write channels,
// predicts every result beat from its own copy of the pattern table, and counts mismatches.
// Depends on lps_pkg for the operation codes only.
`timescale 1ns / 100ps

module lps_pattern_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire         op,
	input  wire  [3:0]  pattern,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [15:0] pin_levels,
	input  wire  [15:0] pin_drive_enable,
	input  wire         accepted,
	input  wire  [3:0]  playing_pattern,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [15:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [15:0] mask;
		logic        lit;
		logic [14:0] ms;
	} blink_step_t;

	typedef struct packed {
		logic [15:0] levels;
		logic [15:0] drives;
		logic        took;
		logic [3:0]  pat;
	} lamp_frame_t;

	lamp_frame_t expected_frames[$];

	logic [15:0] clear_mask;
	logic [3:0]  cur_pat;
	logic [2:0]  nxt_step;
	logic [3:0]  saved_pat;
	logic [2:0]  saved_step;
	logic [14:0] ms_left;
	logic        timer_on;
	logic [15:0] levels;
	logic [15:0] drives;

	function automatic logic pat_loops(input logic [3:0] p);
		return p < 4'd13;
	endfunction

	function automatic logic [2:0] pat_len(input logic [3:0] p);
		unique case (p)
			4'd0: return 3'd1;
			4'd5, 4'd6, 4'd9, 4'd10: return 3'd4;
			4'd7, 4'd8, 4'd14: return 3'd6;
			default: return 3'd2;
		endcase
	endfunction

	function automatic blink_step_t pattern_step(input logic [3:0] p, input logic [2:0] s);
		blink_step_t e;
		e.lit = !s[0];
		unique case (p)
			4'd1, 4'd3, 4'd5, 4'd7: e.mask = 16'h4000;
			4'd2, 4'd4, 4'd6, 4'd8, 4'd14: e.mask = 16'h8000;
			4'd9, 4'd10: e.mask = (s < 3'd2) ? 16'h8000 : 16'h4000;
			default: e.mask = 16'hC000;
		endcase
		unique case (p)
			4'd0: begin
				e.lit = 1'b0;
				e.ms = 15'd0;
			end
			4'd1, 4'd2: e.ms = s[0] ? 15'd200 : 15'd1000;
			4'd10, 4'd12: e.ms = 15'd1000;
			4'd13: e.ms = s[0] ? 15'd100 : 15'd1000;
			4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
				e.ms = (s == pat_len(p) - 3'd1) ? 15'd2400 : 15'd100;
			end
			default: e.ms = 15'd100;
		endcase
		return e;
	endfunction

	task automatic drive_pins(input logic [15:0] m, input logic lit);
		levels = (levels & ~m) | (lit ? m : 16'h0000);
		drives = drives | m;
	endtask

	task automatic apply_next_step();
		logic [2:0]  len;
		blink_step_t e;
		timer_on = 1'b0;
		if (nxt_step >= pat_len(cur_pat)) begin
			if (pat_loops(cur_pat)) begin
				nxt_step = 3'd0;
			end else begin
				cur_pat = saved_pat;
				nxt_step = saved_step;
				if (pat_loops(cur_pat))
					nxt_step = 3'd0;
			end
		end
		len = pat_len(cur_pat);
		if (nxt_step >= len)
			nxt_step = 3'd0;
		e = pattern_step(cur_pat, nxt_step);
		drive_pins(e.mask, e.lit);
		if (len != 3'd1) begin
			ms_left = e.ms;
			timer_on = 1'b1;
		end
		nxt_step = nxt_step + 3'd1;
	endtask

	task automatic play_or_tick(input lps_pkg::op_t o, input logic [3:0] p,
		output lamp_frame_t f);
		logic took;
		took = 1'b0;
		if (o == lps_pkg::OP_PLAY) begin
			if (p < 4'd15) begin
				if (pat_loops(cur_pat)) begin
					if (pat_loops(p)) begin
						saved_pat = p;
						saved_step = 3'd0;
					end else begin
						saved_pat = cur_pat;
						saved_step = nxt_step;
					end
					cur_pat = p;
					nxt_step = 3'd0;
					took = 1'b1;
				end else if (pat_loops(p)) begin
					saved_pat = p;
					saved_step = 3'd0;
					took = 1'b1;
				end
				if (took) begin
					timer_on = 1'b0;
					drive_pins(clear_mask, 1'b0);
					apply_next_step();
				end
			end
		end else if (timer_on) begin
			if (ms_left > 15'd1)
				ms_left = ms_left - 15'd1;
			else
				apply_next_step();
		end
		f.levels = levels;
		f.drives = drives;
		f.took = took;
		f.pat = cur_pat;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lamp_frame_t got;
		lamp_frame_t want;
		if (!arst_n) begin
			clear_mask = 16'hC000;
			cur_pat = 4'd0;
			nxt_step = 3'd0;
			saved_pat = 4'd0;
			saved_step = 3'd0;
			ms_left = 15'd0;
			timer_on = 1'b0;
			levels = 16'h0000;
			drives = 16'h0000;
			expected_frames.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				clear_mask = cfg_data;
			if (out_valid && !out_stall) begin
				got.levels = pin_levels;
				got.drives = pin_drive_enable;
				got.took = accepted;
				got.pat = playing_pattern;
				if (expected_frames.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected beat: levels %h drive %h acc %b pat %0d",
							$realtime, got.levels, got.drives, got.took, got.pat);
					mismatches++;
				end else begin
					want = expected_frames.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("%0t: exp/act levels %h/%h drive %h/%h acc %b/%b pat %0d/%0d",
								$realtime, want.levels, got.levels, want.drives, got.drives,
								want.took, got.took, want.pat, got.pat);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				play_or_tick(lps_pkg::op_t'(op), pattern, want);
				expected_frames.push_back(want);
			end
		end
		pending = expected_frames.size();
	end

endmodule

/* dv/tb_led_pattern_sequencer.sv */
// Testbench top for the LED pattern sequencer: clock, reset, play and tick beats, mask writes
// and random output stalls. Depends on lps_pkg, led_pattern_sequencer and lps_pattern_checker.
`timescale 1ns / 100ps

module tb_led_pattern_sequencer;

	localparam int HOLD_CYCLES = 80;
	localparam int ACTIONS_PER_PHASE = 12;
	localparam int LONG_RUN = 101;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	wire           in_stall;
	lps_pkg::op_t  in_op;
	logic [3:0]    in_pat;
	wire           out_valid;
	logic          out_stall;
	wire  [15:0]   pin_levels;
	wire  [15:0]   pin_drive_enable;
	wire           accepted;
	wire  [3:0]    playing_pattern;
	logic          cfg_valid;
	wire           cfg_ready;
	logic [15:0]   cfg_word;
	int            mismatches;
	int            pending;

	bit tx_calm;
	bit rx_calm;
	bit hold_output;

	led_pattern_sequencer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (in_op),
		.pattern          (in_pat),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pin_levels       (pin_levels),
		.pin_drive_enable (pin_drive_enable),
		.accepted         (accepted),
		.playing_pattern  (playing_pattern),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_word)
	);

	lps_pattern_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (in_op),
		.pattern          (in_pat),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pin_levels       (pin_levels),
		.pin_drive_enable (pin_drive_enable),
		.accepted         (accepted),
		.playing_pattern  (playing_pattern),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_word),
		.mismatches       (mismatches),
		.pending          (pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Output side: a random stall before every beat unless rx_calm is set, plus one long hold on request.
	initial begin : receiver
		int gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_output) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
			end
			gap = rx_calm ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	task automatic send_beat(input lps_pkg::op_t o, input logic [3:0] p);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_op <= o;
		in_pat <= p;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic tick_run(input int n);
		for (int i = 0; i < n; i++)
			send_beat(lps_pkg::OP_TICK, 4'($urandom_range(0, 15)));
	endtask

	task automatic write_clear_mask(input logic [15:0] m);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_word <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_actions(input int count);
		int          roll;
		logic [3:0]  pick;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			tx_calm = ($urandom_range(0, 9) < 3);
			rx_calm = ($urandom_range(0, 9) < 3);
			if (roll < 40) begin
				if ($urandom_range(0, 4) == 0)
					pick = 4'd13 + 4'($urandom_range(0, 1));
				else
					pick = 4'($urandom_range(0, 15));
				send_beat(lps_pkg::OP_PLAY, pick);
			end else begin
				tick_run($urandom_range(1, 4));
			end
		end
	endtask

	initial begin : stimulus
		logic [15:0] masks [4];
		logic [3:0]  long_pat [4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_op = lps_pkg::OP_PLAY;
		in_pat = 4'd0;
		cfg_valid = 1'b0;
		cfg_word = 16'h0000;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_output = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with the mask still at its reset value.
		send_beat(lps_pkg::OP_TICK, 4'd0);
		send_beat(lps_pkg::OP_PLAY, 4'd15);
		send_beat(lps_pkg::OP_PLAY, 4'd0);
		send_beat(lps_pkg::OP_PLAY, 4'd1);
		tick_run(3);
		send_beat(lps_pkg::OP_PLAY, 4'd13);
		send_beat(lps_pkg::OP_PLAY, 4'd14);
		send_beat(lps_pkg::OP_PLAY, 4'd3);
		tx_calm = 1'b1;
		tick_run(LONG_RUN + 1);
		tx_calm = 1'b0;

		masks[0] = 16'hFFFF;
		masks[1] = 16'h0000;
		masks[2] = 16'($urandom);
		masks[3] = 16'h8000;
		long_pat[0] = 4'd11;
		long_pat[1] = 4'd14;
		long_pat[2] = 4'd9;
		long_pat[3] = 4'd7;
		for (int ph = 0; ph < 4; ph++) begin
			write_clear_mask(masks[ph]);
			if (ph == 1) begin
				// Keep offering beats while the output is held off so the input backs up.
				hold_output = 1'b1;
				tx_calm = 1'b1;
				for (int i = 0; i < 40; i++)
					send_beat(i[0] ? lps_pkg::OP_TICK : lps_pkg::OP_PLAY,
						4'($urandom_range(0, 15)));
			end
			random_actions(ACTIONS_PER_PHASE);
			tx_calm = 1'b1;
			send_beat(lps_pkg::OP_PLAY, long_pat[ph]);
			tick_run(LONG_RUN);
			tx_calm = 1'b0;
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
